FILE: hdl/hmp_pkg.sv
`default_nettype none

package hmp_pkg;

	// Microcode step addresses.
	typedef logic [2:0] upc_t;

	localparam upc_t UPC_IDLE = 3'd0;
	localparam upc_t UPC_HEAD = 3'd1;
	localparam upc_t UPC_TEST = 3'd2;
	localparam upc_t UPC_FILL = 3'd3;
	localparam upc_t UPC_LEN  = 3'd4;

	// What a step places in the output register.
	typedef enum logic [1:0] {
		EK_NONE,
		EK_HEAD,
		EK_FILL,
		EK_LEN
	} emit_kind_t;

	// Branch conditions tested by a step.
	typedef enum logic [1:0] {
		CD_ALWAYS,
		CD_START,
		CD_PAD,
		CD_MORE
	} cond_t;

	typedef struct packed {
		emit_kind_t kind;
		cond_t      cond;
		upc_t       jump;
		upc_t       next;
	} uword_t;

	typedef struct packed {
		logic start;
		logic pad;
		logic more;
		logic out_free;
	} seq_status_t;

	typedef struct packed {
		logic       idle;
		logic       emit;
		emit_kind_t kind;
	} seq_ctl_t;

	// Configuration register indexes.
	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_BLOCK_MODE  = 2'd0;
	localparam reg_idx_t REG_LENGTH_MODE = 2'd1;
	localparam reg_idx_t REG_LENGTH_BE   = 2'd2;

	localparam logic [7:0] PAD_MARKER = 8'h80;

	// The padding program: head word, zero fill, then the length field.
	function automatic uword_t hmp_ucode(input upc_t addr);
		uword_t w;
		unique case (addr)
			UPC_IDLE: w = '{EK_NONE, CD_START,  UPC_HEAD, UPC_IDLE};
			UPC_HEAD: w = '{EK_HEAD, CD_ALWAYS, UPC_TEST, UPC_TEST};
			UPC_TEST: w = '{EK_NONE, CD_PAD,    UPC_FILL, UPC_LEN};
			UPC_FILL: w = '{EK_FILL, CD_ALWAYS, UPC_TEST, UPC_TEST};
			UPC_LEN:  w = '{EK_LEN,  CD_MORE,   UPC_LEN,  UPC_IDLE};
			default:  w = '{EK_NONE, CD_ALWAYS, UPC_IDLE, UPC_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [63:0] hmp_bswap(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = v[8*(7-i) +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/hash_message_padder_unit.sv
// Channel   Direction  Handshake              Payload
// msg       in         msg_valid/msg_ready    data_word, byte_count, last
// pad       out        pad_valid/pad_ready    out_word, block_end, message_end
// cfg       in         psel/penable/pready    paddr, pwdata, prdata (APB)
//
// A word that is not last is passed straight to the output register. A last word starts the
// padding program in the microcode sequencer: the head word, then a test step before each
// zero fill word and before the length field words.
// No item is accepted while the program runs; the output register stalls it when pad_ready
// is low. Reset clears the counters, the mode registers and pad_valid and needs no clearing pass.
`default_nettype none

module hash_message_padder_unit #(
	parameter int MAX_BLOCK_BYTES = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         msg_valid,
	output logic        msg_ready,
	input  wire  [63:0] data_word,
	input  wire  [3:0]  byte_count,
	input  wire         last,
	output logic        pad_valid,
	input  wire         pad_ready,
	output logic [63:0] out_word,
	output logic        block_end,
	output logic        message_end,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int WPB    = MAX_BLOCK_BYTES / 8;
	localparam int POS_W  = $clog2(WPB);
	localparam int WPB_W  = POS_W + 1;
	localparam int CNT_W  = POS_W + 2;
	localparam int BYTE_W = $clog2(2 * MAX_BLOCK_BYTES);

	logic              block_mode_q;
	logic              length_mode_q;
	logic              length_be_q;
	logic [POS_W-1:0]  pos_q;
	logic [60:0]       total_q;
	logic [CNT_W-1:0]  remain_q;
	logic              marker_q;
	logic [63:0]       head_q;
	logic [63:0]       bits_q;
	logic              out_valid_q;
	logic [63:0]       out_word_q;
	logic              block_end_q;
	logic              message_end_q;

	hmp_pkg::seq_status_t status;
	hmp_pkg::seq_ctl_t    ctl;

	logic              out_free;
	logic              msg_fire;
	logic              cfg_write;
	hmp_pkg::reg_idx_t reg_idx;
	logic [WPB_W-1:0]  wpb;
	logic [POS_W-1:0]  pos_eff;
	logic              last_pos;
	logic [3:0]        n_clamp;
	logic [BYTE_W-1:0] len_bytes;
	logic [BYTE_W-1:0] end_sum;
	logic [BYTE_W-1:0] block_bytes;
	logic              fits;
	logic [CNT_W-1:0]  count;
	logic [CNT_W-1:0]  len_words;
	logic [60:0]       sum_bytes;
	logic [63:0]       head_word;
	logic              len_value;
	logic              final_word;
	logic [63:0]       emit_word;

	assign out_free  = !out_valid_q || pad_ready;
	assign msg_ready = ctl.idle && out_free;
	assign msg_fire  = msg_valid && msg_ready;
	assign cfg_write = psel && penable && pwrite;
	assign reg_idx   = paddr[3:2];
	assign pready    = 1'b1;

	assign pad_valid   = out_valid_q;
	assign out_word    = out_word_q;
	assign block_end   = block_end_q;
	assign message_end = message_end_q;

	always_comb begin
		unique case (reg_idx)
			hmp_pkg::REG_BLOCK_MODE:  prdata = {31'b0, block_mode_q};
			hmp_pkg::REG_LENGTH_MODE: prdata = {31'b0, length_mode_q};
			hmp_pkg::REG_LENGTH_BE:   prdata = {31'b0, length_be_q};
			default:                  prdata = 32'b0;
		endcase
	end

	// The stored position is reduced to the current block size; it never reaches twice it.
	assign wpb     = block_mode_q ? WPB_W'(WPB) : WPB_W'(8);
	assign pos_eff = block_mode_q ? pos_q :
		(({1'b0, pos_q} >= WPB_W'(8)) ? POS_W'({1'b0, pos_q} - WPB_W'(8)) : pos_q);
	assign last_pos = ({1'b0, pos_eff} == (wpb - WPB_W'(1)));

	assign n_clamp     = (byte_count > 4'd8) ? 4'd8 : byte_count;
	assign len_bytes   = length_mode_q ? BYTE_W'(16) : BYTE_W'(8);
	assign block_bytes = BYTE_W'({wpb, 3'b000});
	assign end_sum     = BYTE_W'({pos_eff, 3'b000}) + BYTE_W'(n_clamp) + BYTE_W'(1) + len_bytes;
	assign fits        = (end_sum <= block_bytes);
	assign count       = (fits ? CNT_W'(wpb) : CNT_W'({wpb, 1'b0})) - CNT_W'(pos_eff);
	assign len_words   = length_mode_q ? CNT_W'(2) : CNT_W'(1);
	assign sum_bytes   = total_q + 61'(n_clamp);

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < n_clamp) begin
				head_word[8*(7-b) +: 8] = data_word[8*(7-b) +: 8];
			end else if (4'(b) == n_clamp) begin
				head_word[8*(7-b) +: 8] = hmp_pkg::PAD_MARKER;
			end else begin
				head_word[8*(7-b) +: 8] = 8'h00;
			end
		end
	end

	// In a 16-byte field only the word nearer the low-order end carries the count.
	assign len_value  = length_mode_q ?
		(length_be_q ? (remain_q == CNT_W'(1)) : (remain_q == CNT_W'(2))) : 1'b1;
	assign final_word = (ctl.kind == hmp_pkg::EK_LEN) && (remain_q == CNT_W'(1));

	always_comb begin
		case (ctl.kind)
			hmp_pkg::EK_HEAD: emit_word = head_q;
			hmp_pkg::EK_FILL: emit_word = marker_q ? {hmp_pkg::PAD_MARKER, 56'b0} : 64'b0;
			hmp_pkg::EK_LEN:  emit_word = !len_value ? 64'b0 :
				(length_be_q ? bits_q : hmp_pkg::hmp_bswap(bits_q));
			default:          emit_word = 64'b0;
		endcase
	end

	assign status.start    = msg_fire && last;
	assign status.pad      = (remain_q > len_words);
	assign status.more     = (remain_q != CNT_W'(1));
	assign status.out_free = out_free;

	hmp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_mode_q  <= 1'b0;
			length_mode_q <= 1'b0;
			length_be_q   <= 1'b0;
			pos_q         <= '0;
			total_q       <= '0;
			remain_q      <= '0;
			marker_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (reg_idx)
					hmp_pkg::REG_BLOCK_MODE:  block_mode_q  <= pwdata[0];
					hmp_pkg::REG_LENGTH_MODE: length_mode_q <= pwdata[0];
					hmp_pkg::REG_LENGTH_BE:   length_be_q   <= pwdata[0];
					default: ;
				endcase
			end
			if (pad_valid && pad_ready) begin
				out_valid_q <= 1'b0;
			end
			if (msg_fire) begin
				if (last) begin
					pos_q    <= pos_eff;
					remain_q <= count;
					marker_q <= (n_clamp == 4'd8);
				end else begin
					out_valid_q <= 1'b1;
					pos_q       <= last_pos ? '0 : pos_eff + POS_W'(1);
					total_q     <= total_q + 61'd8;
				end
			end else if (ctl.emit) begin
				out_valid_q <= 1'b1;
				remain_q    <= remain_q - CNT_W'(1);
				if (ctl.kind == hmp_pkg::EK_FILL) begin
					marker_q <= 1'b0;
				end
				if (final_word) begin
					pos_q   <= '0;
					total_q <= '0;
				end else begin
					pos_q <= last_pos ? '0 : pos_eff + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (msg_fire) begin
			head_q        <= head_word;
			bits_q        <= {sum_bytes, 3'b000};
			out_word_q    <= data_word;
			block_end_q   <= last_pos;
			message_end_q <= 1'b0;
		end else if (ctl.emit) begin
			out_word_q    <= emit_word;
			block_end_q   <= last_pos;
			message_end_q <= final_word;
		end
	end

	// The padded message always closes a block.
	a_end_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		pad_valid && message_end |-> block_end)
		else $error("message end not on a block boundary");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		msg_fire && last |=> !msg_ready)
		else $error("item accepted while padding");

	a_remain_live: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.idle |-> remain_q != '0)
		else $error("padding program running with no words left");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && final_word |=> pos_q == '0 && total_q == '0 && ctl.idle)
		else $error("message state not cleared after final word");

endmodule

`default_nettype wire

FILE: hdl/hmp_seq.sv
`default_nettype none

module hmp_seq (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire hmp_pkg::seq_status_t status,
	output hmp_pkg::seq_ctl_t         ctl
);

	hmp_pkg::upc_t   upc_q;
	hmp_pkg::uword_t uw;
	logic            taken;
	logic            advance;

	assign uw = hmp_pkg::hmp_ucode(upc_q);

	always_comb begin
		case (uw.cond)
			hmp_pkg::CD_START: taken = status.start;
			hmp_pkg::CD_PAD:   taken = status.pad;
			hmp_pkg::CD_MORE:  taken = status.more;
			default:           taken = 1'b1;
		endcase
	end

	// A step that writes the output register waits until that register is free.
	assign advance  = (uw.kind == hmp_pkg::EK_NONE) || status.out_free;
	assign ctl.idle = (upc_q == hmp_pkg::UPC_IDLE);
	assign ctl.kind = uw.kind;
	assign ctl.emit = (uw.kind != hmp_pkg::EK_NONE) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= hmp_pkg::UPC_IDLE;
		end else if (advance) begin
			upc_q <= taken ? uw.jump : uw.next;
		end
	end

endmodule

`default_nettype wire

FILE: sim/hash_message_padder_unit_tb.sv
module hash_message_padder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BLOCK_BYTES = 128;

	typedef struct packed {
		logic [63:0] word;
		logic        blk_end;
		logic        msg_end;
	} pad_word_t;

	// One row of the directed table: either a register write or an input item.
	typedef struct packed {
		logic              is_cfg;
		hmp_pkg::reg_idx_t ridx;
		logic              val;
		logic [63:0]       data;
		logic [3:0]        cnt;
		logic              lst;
		logic              typed;
		pad_word_t         head;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_ready;
	logic [63:0] data_word = '0;
	logic [3:0]  byte_count = '0;
	logic        last = 1'b0;
	logic        pad_valid;
	logic        pad_ready = 1'b0;
	logic [63:0] out_word;
	logic        block_end;
	logic        message_end;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Typed expectation for the first result of the item on the bus, if any.
	logic        head_typed = 1'b0;
	pad_word_t   head_exp = '0;

	// Predictor state and its copy of the registers.
	logic        cfg_blk = 1'b0;
	logic        cfg_len16 = 1'b0;
	logic        cfg_be = 1'b0;
	logic [3:0]  word_pos = '0;
	logic [60:0] byte_total = '0;

	pad_word_t   padded_q[$];
	dir_row_t    dir_tab[$];
	int          mismatches = 0;
	int          words_sent = 0;
	int          tx_idle_pct = 26;
	int          rx_idle_pct = 70;

	hash_message_padder_unit #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.data_word(data_word),
		.byte_count(byte_count),
		.last(last),
		.pad_valid(pad_valid),
		.pad_ready(pad_ready),
		.out_word(out_word),
		.block_end(block_end),
		.message_end(message_end),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(negedge clk) begin
		pad_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Works out the padded words caused by one input word and queues them.
	function automatic void pad_message(input logic [63:0] d, input logic [3:0] c,
			input logic l);
		int bs, words, p, n, len, s, fin, span, k, idx, e;
		logic [60:0] total;
		logic [63:0] bits;
		logic [63:0] w;
		logic [7:0]  b;
		pad_word_t   r;
		bs = cfg_blk ? MAX_BLOCK_BYTES : 64;
		words = bs / 8;
		p = int'(word_pos) % words;
		n = (c > 4'd8) ? 8 : int'(c);
		w = '0;
		if (!l) begin
			r.word = d;
			r.blk_end = (p + 1 == words);
			r.msg_end = 1'b0;
			padded_q.push_back(r);
			word_pos = 4'((p + 1) % words);
			byte_total = byte_total + 61'd8;
		end else begin
			len = cfg_len16 ? 16 : 8;
			s = p * 8;
			fin = s + n + 1;
			// The marker and the length field must both fit, else a block is added.
			span = (fin <= bs && bs - fin >= len) ? bs - s : 2 * bs - s;
			total = byte_total + 61'(n);
			bits = {total, 3'b000};
			for (k = 0; k < span; k++) begin
				if (k < n) begin
					b = d[63 - 8 * k -: 8];
				end else if (k == n) begin
					b = 8'h80;
				end else if (k >= span - len) begin
					idx = k - (span - len);
					e = cfg_be ? len - 1 - idx : idx;
					b = (e < 8) ? bits[8 * e +: 8] : 8'h00;
				end else begin
					b = 8'h00;
				end
				w = {w[55:0], b};
				if (k % 8 == 7) begin
					r.word = w;
					r.blk_end = ((s + k + 1) % bs == 0);
					r.msg_end = (k + 1 == span);
					padded_q.push_back(r);
				end
			end
			word_pos = '0;
			byte_total = '0;
		end
	endfunction

	always @(posedge clk) begin : monitor
		int        head_idx;
		pad_word_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (hmp_pkg::reg_idx_t'(paddr[3:2]))
					hmp_pkg::REG_BLOCK_MODE:  cfg_blk = pwdata[0];
					hmp_pkg::REG_LENGTH_MODE: cfg_len16 = pwdata[0];
					hmp_pkg::REG_LENGTH_BE:   cfg_be = pwdata[0];
					default: ;
				endcase
			end
			if (msg_valid && msg_ready) begin
				head_idx = padded_q.size();
				pad_message(data_word, byte_count, last);
				if (head_typed) begin
					padded_q[head_idx] = head_exp;
				end
			end
			if (pad_valid && pad_ready) begin
				if (padded_q.size() == 0) begin
					$error("unexpected padded word %h", out_word);
					mismatches++;
				end else begin
					want = padded_q.pop_front();
					if (out_word !== want.word) begin
						$error("out_word: expected %h, got %h", want.word, out_word);
						mismatches++;
					end
					if (block_end !== want.blk_end) begin
						$error("block_end: expected %b, got %b", want.blk_end, block_end);
						mismatches++;
					end
					if (message_end !== want.msg_end) begin
						$error("message_end: expected %b, got %b", want.msg_end, message_end);
						mismatches++;
					end
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input logic [63:0] d, input logic [3:0] c, input logic l,
			input logic ty, input pad_word_t hd);
		if (words_sent < 110) begin
			tx_idle_pct = 26;
			rx_idle_pct = 70;
		end else if (words_sent < 220) begin
			tx_idle_pct = 70;
			rx_idle_pct = 26;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg_valid <= 1'b1;
		data_word <= d;
		byte_count <= c;
		last <= l;
		head_typed <= ty;
		head_exp <= hd;
		do @(posedge clk); while (!msg_ready);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		msg_valid <= 1'b0;
		while (padded_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input hmp_pkg::reg_idx_t idx, input logic v);
		paddr <= {idx, 2'b00};
		pwdata <= {31'd0, v};
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic dir_row_t row_cfg(input hmp_pkg::reg_idx_t idx, input logic v);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.ridx = idx;
		r.val = v;
		return r;
	endfunction

	function automatic dir_row_t row_chk(input logic [63:0] d, input logic [3:0] c,
			input logic l, input logic ty, input logic [63:0] hw, input logic hb,
			input logic hm);
		dir_row_t r;
		r = '0;
		r.data = d;
		r.cnt = c;
		r.lst = l;
		r.typed = ty;
		r.head.word = hw;
		r.head.blk_end = hb;
		r.head.msg_end = hm;
		return r;
	endfunction

	initial begin
		int        i, n_words, switch_at;
		logic [3:0] cnt;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		dir_tab.push_back(row_cfg(hmp_pkg::REG_BLOCK_MODE, 1'b0));
		dir_tab.push_back(row_cfg(hmp_pkg::REG_LENGTH_MODE, 1'b0));
		dir_tab.push_back(row_cfg(hmp_pkg::REG_LENGTH_BE, 1'b0));
		// Empty message: the marker opens the only block.
		dir_tab.push_back(row_chk(64'h0, 4'd0, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 1'b0, 1'b0));
		dir_tab.push_back(row_chk('1, 4'd8, 1'b1, 1'b1, '1, 1'b0, 1'b0));
		// A count above eight behaves as a full word.
		dir_tab.push_back(row_chk(64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 1'b1,
			64'h0123_4567_89AB_CDEF, 1'b0, 1'b0));
		// The unused bytes of the last word are replaced by padding.
		dir_tab.push_back(row_chk(64'hAABB_CCDD_EEFF_0011, 4'd3, 1'b1, 1'b1,
			64'hAABB_CC80_0000_0000, 1'b0, 1'b0));
		// A short word that is not last goes through whole.
		dir_tab.push_back(row_chk(64'h1234_5678_90AB_CDEF, 4'd2, 1'b0, 1'b1,
			64'h1234_5678_90AB_CDEF, 1'b0, 1'b0));
		dir_tab.push_back(row_chk(64'h0, 4'd0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
		dir_tab.push_back(row_cfg(hmp_pkg::REG_LENGTH_BE, 1'b1));
		for (i = 0; i < 7; i++) begin
			dir_tab.push_back(row_chk({8{8'(i * 17)}}, 4'd8, 1'b0, 1'b0, '0, 1'b0, 1'b0));
		end
		// A full last word that ends a block pushes the marker into a new block.
		dir_tab.push_back(row_chk(64'hFEDC_BA98_7654_3210, 4'd8, 1'b1, 1'b1,
			64'hFEDC_BA98_7654_3210, 1'b1, 1'b0));
		dir_tab.push_back(row_cfg(hmp_pkg::REG_LENGTH_MODE, 1'b1));
		dir_tab.push_back(row_chk(64'h1122_3344_5566_7788, 4'd7, 1'b1, 1'b1,
			64'h1122_3344_5566_7780, 1'b0, 1'b0));
		dir_tab.push_back(row_cfg(hmp_pkg::REG_BLOCK_MODE, 1'b1));
		for (i = 0; i < 9; i++) begin
			dir_tab.push_back(row_chk({2{32'h0F0F_0F0F ^ 32'(i)}}, 4'd8, 1'b0, 1'b0, '0,
				1'b0, 1'b0));
		end
		// Shrinking the block mid-message wraps the word position.
		dir_tab.push_back(row_cfg(hmp_pkg::REG_BLOCK_MODE, 1'b0));
		dir_tab.push_back(row_chk(64'hC3C3_C3C3_C3C3_C3C3, 4'd4, 1'b1, 1'b0, '0, 1'b0, 1'b0));
		dir_tab.push_back(row_cfg(hmp_pkg::REG_BLOCK_MODE, 1'b1));
		dir_tab.push_back(row_cfg(hmp_pkg::REG_LENGTH_BE, 1'b0));
		dir_tab.push_back(row_chk('1, 4'd15, 1'b1, 1'b0, '0, 1'b0, 1'b0));

		foreach (dir_tab[k]) begin
			if (dir_tab[k].is_cfg) begin
				wait_idle();
				write_reg(dir_tab[k].ridx, dir_tab[k].val);
			end else begin
				send_word(dir_tab[k].data, dir_tab[k].cnt, dir_tab[k].lst, dir_tab[k].typed,
					dir_tab[k].head);
			end
		end

		// Random messages: mostly full random words, now and then a short one inside,
		// random register settings between messages and a block size flip within.
		while (words_sent < 326) begin
			if ($urandom_range(0, 2) == 0) begin
				wait_idle();
				write_reg(hmp_pkg::REG_BLOCK_MODE, 1'($urandom_range(0, 1)));
				write_reg(hmp_pkg::REG_LENGTH_MODE, 1'($urandom_range(0, 1)));
				write_reg(hmp_pkg::REG_LENGTH_BE, 1'($urandom_range(0, 1)));
			end
			n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
			switch_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_words) : -1;
			for (i = 0; i < n_words; i++) begin
				if (i == switch_at) begin
					wait_idle();
					write_reg(hmp_pkg::REG_BLOCK_MODE, ~cfg_blk);
				end
				cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
				send_word({$urandom, $urandom}, cnt, 1'b0, 1'b0, '0);
			end
			cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			send_word({$urandom, $urandom}, cnt, 1'b1, 1'b0, '0);
		end

		msg_valid <= 1'b0;
		while (padded_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: hash_message_padder_unit.f
hdl/hmp_pkg.sv
hdl/hmp_seq.sv
hdl/hash_message_padder_unit.sv
sim/hash_message_padder_unit_tb.sv
